### hdl/pid_controller_clamped_integral_core_assert.svh
// Assertion macros for the verification checker of the PID core.
// No dependencies; included by the checker module.
`ifndef PID_CONTROLLER_CLAMPED_INTEGRAL_CORE_ASSERT_SVH
`define PID_CONTROLLER_CLAMPED_INTEGRAL_CORE_ASSERT_SVH

// Same-cycle implication under reset.
`define PIDC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pidc assertion failed");

// Next-cycle implication under reset.
`define PIDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pidc assertion failed");

`endif

### hdl/pidc_pkg.sv
// Shared types and constants for the clamped-integral PID core.
// No dependencies; imported by every module of the core.
package pidc_pkg;

	localparam int unsigned SAMPLE_W = 10;
	localparam int unsigned GAIN_W   = 16;
	localparam int unsigned OFFSET_W = 8;
	localparam int unsigned ERR_W    = 11;
	localparam int unsigned INTEG_W  = 14;
	localparam int unsigned DELTA_W  = 12;
	localparam int unsigned DRIVE_W  = 8;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned ACC_W    = 32;
	localparam int unsigned SCALE_SHIFT = 8;

	localparam logic signed [INTEG_W:0] INTEG_MAX = 15'sd8000;
	localparam logic signed [INTEG_W:0] INTEG_MIN = -15'sd8000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SETPOINT = 3'd0,
		REG_GAIN_P   = 3'd1,
		REG_GAIN_I   = 3'd2,
		REG_GAIN_D   = 3'd3,
		REG_OFFSET   = 3'd4
	} reg_idx_t;

	// One classified sample, as queued between front and back.
	typedef struct packed {
		logic signed [ERR_W-1:0]   err;
		logic signed [INTEG_W-1:0] integ;
		logic signed [DELTA_W-1:0] delta;
	} work_t;

	// Gains and offset consumed by the back end.
	typedef struct packed {
		logic signed [GAIN_W-1:0] kp;
		logic signed [GAIN_W-1:0] ki;
		logic signed [GAIN_W-1:0] kd;
		logic [OFFSET_W-1:0]      offset;
	} coef_t;

endpackage

### hdl/pidc_front.sv
// Front end: accept samples, form error, clamped integral and derivative delta.
// Depends on pidc_pkg.
module pidc_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	output logic                          sample_ready,
	input  logic [pidc_pkg::SAMPLE_W-1:0] sample,
	input  logic [pidc_pkg::SAMPLE_W-1:0] setpoint,
	output logic                          push_valid,
	input  logic                          push_ready,
	output pidc_pkg::work_t               push_data
);
	import pidc_pkg::*;

	logic signed [ERR_W-1:0]   prev_error_q;
	logic signed [INTEG_W-1:0] integral_q;
	logic signed [ERR_W-1:0]   err_w;
	logic signed [INTEG_W:0]   sum_w;
	logic signed [INTEG_W-1:0] clamp_w;
	logic                      take_w;

	assign err_w = signed'({1'b0, setpoint}) - signed'({1'b0, sample});
	assign sum_w = (INTEG_W+1)'(integral_q) + (INTEG_W+1)'(err_w);

	// Saturate the running sum
	always_comb begin
		if (sum_w > INTEG_MAX) begin
			clamp_w = INTEG_W'(INTEG_MAX);
		end else if (sum_w < INTEG_MIN) begin
			clamp_w = INTEG_W'(INTEG_MIN);
		end else begin
			clamp_w = sum_w[INTEG_W-1:0];
		end
	end

	assign sample_ready    = push_ready;
	assign take_w          = sample_valid && push_ready;
	assign push_valid      = sample_valid;
	assign push_data.err   = err_w;
	assign push_data.integ = clamp_w;
	assign push_data.delta = DELTA_W'(err_w) - DELTA_W'(prev_error_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_error_q <= '0;
			integral_q   <= '0;
		end else if (take_w) begin
			prev_error_q <= err_w;
			integral_q   <= clamp_w;
		end
	end

endmodule

### hdl/pidc_fifo.sv
// Short queue decoupling the front end from the back end.
// Depends on pidc_pkg for the entry type.
module pidc_fifo #(
	parameter int unsigned DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  pidc_pkg::work_t push_data,
	output logic            pop_valid,
	input  logic            pop_ready,
	output pidc_pkg::work_t pop_data
);
	import pidc_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	work_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push_w;
	logic             pop_w;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push_w     = push_valid && push_ready;
	assign pop_w      = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push_w) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_w) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_w) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push_w, pop_w})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### hdl/pidc_back.sv
// Back end: three gain products, then sum, scale by 1/256 and add offset.
// Depends on pidc_pkg.
module pidc_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             pop_valid,
	output logic                             pop_ready,
	input  pidc_pkg::work_t                  pop_data,
	input  pidc_pkg::coef_t                  coef,
	output logic                             result_valid,
	input  logic                             result_ready,
	output logic [pidc_pkg::DRIVE_W-1:0]     drive,
	output logic signed [pidc_pkg::ERR_W-1:0]   error_now,
	output logic signed [pidc_pkg::INTEG_W-1:0] integral_now
);
	import pidc_pkg::*;

	localparam int unsigned PP_W = GAIN_W + ERR_W;
	localparam int unsigned PI_W = GAIN_W + INTEG_W;
	localparam int unsigned PD_W = GAIN_W + DELTA_W;

	logic                      v_s1;
	logic signed [PP_W-1:0]    prod_p_s1;
	logic signed [PI_W-1:0]    prod_i_s1;
	logic signed [PD_W-1:0]    prod_d_s1;
	logic signed [ERR_W-1:0]   err_s1;
	logic signed [INTEG_W-1:0] integ_s1;

	logic                      v_s2;
	logic [DRIVE_W-1:0]        drive_s2;
	logic signed [ERR_W-1:0]   err_s2;
	logic signed [INTEG_W-1:0] integ_s2;

	logic                      adv1_w;
	logic                      adv2_w;
	logic signed [ACC_W-1:0]   acc_w;
	logic [ACC_W-1:0]          adj_w;

	assign adv2_w    = !v_s2 || result_ready;
	assign adv1_w    = !v_s1 || adv2_w;
	assign pop_ready = adv1_w;

	// Round toward zero: bias negative sums by 255 before the shift
	assign acc_w = ACC_W'(prod_p_s1) + ACC_W'(prod_i_s1) + ACC_W'(prod_d_s1);
	assign adj_w = acc_w + {{(ACC_W-SCALE_SHIFT){1'b0}}, {SCALE_SHIFT{acc_w[ACC_W-1]}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1_w) begin
				v_s1 <= pop_valid;
			end
			if (adv2_w) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1_w && pop_valid) begin
			prod_p_s1 <= PP_W'(coef.kp) * PP_W'(pop_data.err);
			prod_i_s1 <= PI_W'(coef.ki) * PI_W'(pop_data.integ);
			prod_d_s1 <= PD_W'(coef.kd) * PD_W'(pop_data.delta);
			err_s1    <= pop_data.err;
			integ_s1  <= pop_data.integ;
		end
		if (adv2_w && v_s1) begin
			drive_s2 <= adj_w[SCALE_SHIFT +: DRIVE_W] + coef.offset;
			err_s2   <= err_s1;
			integ_s2 <= integ_s1;
		end
	end

	assign result_valid = v_s2;
	assign drive        = drive_s2;
	assign error_now    = err_s2;
	assign integral_now = integ_s2;

endmodule

### hdl/pid_controller_clamped_integral_core.sv
// Clamped-integral PID core: one result per sample, one sample per cycle sustained while results are taken.
// Path: an accepted sample is written into the queue, then passes the multiply stage and the output register.
// Throughput: one sample per cycle while result_ready stays high.
// The queue between front and back (FIFO_DEPTH entries) lets each side stall alone.
// Reset (arst_n low, asynchronous) clears config registers, integral, previous error
// and all valid flags; depends on pidc_pkg, pidc_front, pidc_fifo and pidc_back.
module pid_controller_clamped_integral_core #(
	parameter int unsigned FIFO_DEPTH = 2
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [pidc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pidc_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               sample_valid,
	output logic                               sample_ready,
	input  logic [pidc_pkg::SAMPLE_W-1:0]      sample,
	output logic                               result_valid,
	input  logic                               result_ready,
	output logic [pidc_pkg::DRIVE_W-1:0]       drive,
	output logic signed [pidc_pkg::ERR_W-1:0]   error_now,
	output logic signed [pidc_pkg::INTEG_W-1:0] integral_now
);
	import pidc_pkg::*;

	// Configuration registers; the user must write them only while the core is idle, the block does not enforce it
	logic [SAMPLE_W-1:0] setpoint_q;
	coef_t               coef_q;

	// Front-to-queue and queue-to-back transactions
	logic  push_valid;
	logic  push_ready;
	work_t push_data;
	logic  pop_valid;
	logic  pop_ready;
	work_t pop_data;

	// Decode the register write; drop writes to unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q <= '0;
			coef_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SETPOINT: setpoint_q    <= cfg_data[SAMPLE_W-1:0];
				REG_GAIN_P:   coef_q.kp     <= cfg_data[GAIN_W-1:0];
				REG_GAIN_I:   coef_q.ki     <= cfg_data[GAIN_W-1:0];
				REG_GAIN_D:   coef_q.kd     <= cfg_data[GAIN_W-1:0];
				REG_OFFSET:   coef_q.offset <= cfg_data[OFFSET_W-1:0];
				default:      setpoint_q    <= setpoint_q;
			endcase
		end
	end

	// Front: error, saturated integral and derivative delta; owns the loop state
	pidc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.setpoint     (setpoint_q),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_data    (push_data)
	);

	// Queue: hold classified samples while the back end is stalled
	pidc_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// Back: multiply, then sum, scale and offset into the output register
	pidc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_data     (pop_data),
		.coef         (coef_q),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.drive        (drive),
		.error_now    (error_now),
		.integral_now (integral_now)
	);

endmodule

### hdl/pidc_checker.sv
// Port-level checker for the PID core, attached by bind below.
// Depends on pidc_pkg and the assertion macro header.
`include "pid_controller_clamped_integral_core_assert.svh"

module pidc_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               sample_valid,
	input logic                               sample_ready,
	input logic                               result_valid,
	input logic                               result_ready,
	input logic [pidc_pkg::DRIVE_W-1:0]       drive,
	input logic signed [pidc_pkg::ERR_W-1:0]   error_now,
	input logic signed [pidc_pkg::INTEG_W-1:0] integral_now
);
	import pidc_pkg::*;

	// A pending result holds until taken
	`PIDC_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(drive) && $stable(integral_now))

	// Integral stays inside the saturation window
	`PIDC_ASSERT_IMPLY(a_integ_range, clk, arst_n, result_valid, (integral_now <= 14'sd8000) && (integral_now >= -14'sd8000))

	// A 10-bit difference never reaches the most negative 11-bit code
	`PIDC_ASSERT_IMPLY(a_err_range, clk, arst_n, result_valid, error_now != -11'sd1024)

	// Nothing is presented right after reset releases
	`PIDC_ASSERT_IMPLY(a_reset_empty, clk, arst_n, $rose(arst_n), !result_valid)

endmodule

bind pid_controller_clamped_integral_core pidc_checker u_pidc_checker (.*);

### tb/sv/pid_controller_clamped_integral_core_check.sv
// Checker for the clamped-integral PID core: watches the config port and both channels,
// predicts each result, compares it with the block's output and counts failures.
// Depends on pidc_pkg for widths and register indexes.
module pid_controller_clamped_integral_core_check (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pidc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pidc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                sample_valid,
	input  logic                                sample_ready,
	input  logic [pidc_pkg::SAMPLE_W-1:0]       sample,
	input  logic                                result_valid,
	input  logic                                result_ready,
	input  logic [pidc_pkg::DRIVE_W-1:0]        drive,
	input  logic signed [pidc_pkg::ERR_W-1:0]   error_now,
	input  logic signed [pidc_pkg::INTEG_W-1:0] integral_now,
	output int unsigned                         fail_count,
	output int unsigned                         outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import pidc_pkg::*;

	localparam int SUM_LIMIT = 8000;
	localparam int QUOTIENT_DIV = 256;

	typedef struct packed {
		logic [DRIVE_W-1:0]        drive;
		logic signed [ERR_W-1:0]   err;
		logic signed [INTEG_W-1:0] integ;
	} control_out_t;

	// Shadow of the configuration registers.
	logic [SAMPLE_W-1:0]       target;
	logic signed [GAIN_W-1:0]  kp;
	logic signed [GAIN_W-1:0]  ki;
	logic signed [GAIN_W-1:0]  kd;
	logic [OFFSET_W-1:0]       offset;

	// Controller state as the block should hold it.
	logic signed [ERR_W-1:0]   last_error;
	logic signed [INTEG_W-1:0] running_sum;

	control_out_t pending_controls[$];

	function automatic control_out_t predict_control(input logic [SAMPLE_W-1:0] value);
		logic signed [ERR_W-1:0]  err;
		logic signed [INTEG_W:0]  clamped;
		longint                   acc;
		longint                   quotient;
		control_out_t             r;
		err = $signed({1'b0, target}) - $signed({1'b0, value});
		clamped = running_sum + err;
		if (clamped > SUM_LIMIT)
			clamped = (INTEG_W+1)'(SUM_LIMIT);
		else if (clamped < -SUM_LIMIT)
			clamped = (INTEG_W+1)'(-SUM_LIMIT);
		acc = longint'(kp) * longint'(err)
			+ longint'(ki) * longint'(clamped)
			+ longint'(kd) * (longint'(err) - longint'(last_error));
		quotient = acc / QUOTIENT_DIV;
		r.drive = quotient[DRIVE_W-1:0] + offset;
		r.err = err;
		r.integ = clamped[INTEG_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		control_out_t want;
		control_out_t got;
		bit           bad;
		if (!arst_n) begin
			target = '0;
			kp = '0;
			ki = '0;
			kd = '0;
			offset = '0;
			last_error = '0;
			running_sum = '0;
			pending_controls.delete();
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SETPOINT: target = cfg_data[SAMPLE_W-1:0];
					REG_GAIN_P:   kp = cfg_data;
					REG_GAIN_I:   ki = cfg_data;
					REG_GAIN_D:   kd = cfg_data;
					REG_OFFSET:   offset = cfg_data[OFFSET_W-1:0];
					default:      ;
				endcase
			end
			// Retire before predicting, so a new expectation never hides a stray result.
			if (result_valid && result_ready) begin
				got.drive = drive;
				got.err = error_now;
				got.integ = integral_now;
				if (pending_controls.size() == 0) begin
					$error("result with no expectation: drive %0d error %0d integral %0d",
						got.drive, got.err, got.integ);
					fail_count <= fail_count + 1;
				end else begin
					want = pending_controls.pop_front();
					bad = 1'b0;
					if (got.drive !== want.drive) begin
						$error("drive: expected %0d, actual %0d", want.drive, got.drive);
						bad = 1'b1;
					end
					if (got.err !== want.err) begin
						$error("error_now: expected %0d, actual %0d", want.err, got.err);
						bad = 1'b1;
					end
					if (got.integ !== want.integ) begin
						$error("integral_now: expected %0d, actual %0d", want.integ, got.integ);
						bad = 1'b1;
					end
					if (bad)
						fail_count <= fail_count + 1;
				end
			end
			if (sample_valid && sample_ready) begin
				want = predict_control(sample);
				last_error = want.err;
				running_sum = want.integ;
				pending_controls.push_back(want);
			end
			outstanding <= pending_controls.size();
		end
	end

endmodule

### tb/sv/pid_controller_clamped_integral_core_test.sv
// Top of the PID core testbench: clock, reset, config writes, sample stimulus,
// result back-pressure and the verdict. Depends on pidc_pkg, the core and the checker.
module pid_controller_clamped_integral_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import pidc_pkg::*;

	localparam int PHASES = 9;
	localparam int ITEMS_PER_PHASE = 84;
	localparam int STALL_LIMIT = 4000;
	localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
	localparam logic [SAMPLE_W-1:0] SAMPLE_TOP = SAMPLE_W'(SAMPLE_MAX);
	localparam logic [GAIN_W-1:0] GAIN_MAX = 16'h7FFF;
	localparam logic [GAIN_W-1:0] GAIN_MIN = 16'h8000;
	localparam logic [OFFSET_W-1:0] OFFSET_MAX = 8'hFF;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]         cfg_index = '0;
	logic [CFG_DATA_W-1:0]        cfg_data = '0;
	logic                         sample_valid = 1'b0;
	logic                         sample_ready;
	logic [SAMPLE_W-1:0]          sample = '0;
	logic                         result_valid;
	logic                         result_ready = 1'b0;
	logic [DRIVE_W-1:0]           drive;
	logic signed [ERR_W-1:0]      error_now;
	logic signed [INTEG_W-1:0]    integral_now;

	int unsigned fail_count;
	int unsigned outstanding;
	int          sender_idle_pct = 0;
	int          receiver_idle_pct = 0;
	int          stall_cycles = 0;

	pid_controller_clamped_integral_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.drive        (drive),
		.error_now    (error_now),
		.integral_now (integral_now)
	);

	pid_controller_clamped_integral_core_check u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.drive        (drive),
		.error_now    (error_now),
		.integral_now (integral_now),
		.fail_count   (fail_count),
		.outstanding  (outstanding)
	);

	// 10 ns clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result back-pressure: drop ready at random in the current share of cycles.
	always @(posedge clk) begin
		result_ready <= ($urandom_range(99, 0) >= receiver_idle_pct);
	end

	// Watchdog: any transaction or config write rearms it; a long silence ends the run.
	always @(posedge clk) begin
		if (!arst_n || (sample_valid && sample_ready) || (result_valid && result_ready) || cfg_we) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic set_idling(input int sender_pct, input int receiver_pct);
		sender_idle_pct <= sender_pct;
		receiver_idle_pct <= receiver_pct;
	endtask

	// Offer one sample and hold it until the transaction completes. A gap, if drawn,
	// comes before the offer so that valid is never dropped while an item waits.
	task automatic send_sample(input logic [SAMPLE_W-1:0] value);
		if ($urandom_range(99, 0) < sender_idle_pct) begin
			sample_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99, 0) < sender_idle_pct);
		end
		sample_valid <= 1'b1;
		sample <= value;
		do @(posedge clk); while (!sample_ready);
	endtask

	// Stop offering samples and wait until every expected result is out, then let the
	// pipeline settle.
	task automatic drain;
		sample_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Hold cfg_we high across back-to-back writes; the caller lowers it.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
	endtask

	// Write every register. Junk lands above the narrow fields so that truncation is
	// exercised, and one write goes to an unused index that the block must ignore.
	task automatic write_config(
		input logic [SAMPLE_W-1:0] target,
		input logic [GAIN_W-1:0]   kp,
		input logic [GAIN_W-1:0]   ki,
		input logic [GAIN_W-1:0]   kd,
		input logic [OFFSET_W-1:0] offset
	);
		logic [CFG_IDX_W-1:0] unused_index;
		unused_index = CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, REG_OFFSET + 1));
		write_reg(REG_SETPOINT, {6'($urandom), target});
		write_reg(REG_GAIN_P, kp);
		write_reg(REG_GAIN_I, ki);
		write_reg(REG_GAIN_D, kd);
		write_reg(REG_OFFSET, {8'($urandom), offset});
		write_reg(unused_index, 16'($urandom));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Gains lean on the extremes; small ones keep the drive byte from pure noise.
	function automatic logic [GAIN_W-1:0] pick_gain();
		case ($urandom_range(4, 0))
			0:       return GAIN_MAX;
			1:       return GAIN_MIN;
			2:       return '0;
			3:       return 16'($signed($urandom_range(1024, 0)) - 512);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_setpoint();
		case ($urandom_range(3, 0))
			0:       return '0;
			1:       return SAMPLE_TOP;
			default: return SAMPLE_W'($urandom_range(SAMPLE_MAX, 0));
		endcase
	endfunction

	initial begin
		int                  phase;
		int                  sent;
		int                  run_len;
		bit                  push_up;
		bit                  biased;
		logic [SAMPLE_W-1:0] target;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset config (all zero gains) with both sample extremes.
		set_idling(0, 0);
		send_sample('0);
		send_sample(SAMPLE_TOP);
		drain();

		// Largest error with extreme gains: run the integral into its upper clamp,
		// then swing the error from full scale to zero for the largest derivative.
		write_config(SAMPLE_TOP, GAIN_MAX, GAIN_MIN, GAIN_MAX, OFFSET_MAX);
		repeat (9) send_sample('0);
		send_sample(SAMPLE_TOP);
		drain();

		// Opposite signs and the most negative error; midscale sample at the end.
		write_config('0, GAIN_MIN, GAIN_MAX, GAIN_MIN, '0);
		repeat (3) send_sample(SAMPLE_TOP);
		send_sample('0);
		send_sample(SAMPLE_W'(SAMPLE_MAX / 2 + 1));
		drain();

		// Random phases: receiver-heavy idling, then sender-heavy, then none.
		for (phase = 0; phase < PHASES; phase++) begin
			case (phase / 3)
				0:       set_idling(24, 87);
				1:       set_idling(87, 24);
				default: set_idling(0, 0);
			endcase
			target = pick_setpoint();
			write_config(target, pick_gain(), pick_gain(), pick_gain(), 8'($urandom));
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				// Mostly one-sided runs that walk the integral into a clamp and back,
				// with the rest plain noise.
				biased = ($urandom_range(99, 0) < 75);
				push_up = 1'($urandom_range(1, 0));
				run_len = biased ? $urandom_range(40, 1) : $urandom_range(12, 1);
				if (run_len > ITEMS_PER_PHASE - sent)
					run_len = ITEMS_PER_PHASE - sent;
				repeat (run_len) begin
					if (!biased)
						send_sample(SAMPLE_W'($urandom_range(SAMPLE_MAX, 0)));
					else if (push_up)
						send_sample(SAMPLE_W'($urandom_range(target, 0)));
					else
						send_sample(SAMPLE_W'($urandom_range(SAMPLE_MAX, target)));
					sent++;
				end
			end
			drain();
		end

		// Every result is in; give the verdict.
		repeat (5) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
